FILE: design/phone_line_call_controller_assert.svh
// assertion macros used by the call state machine
`ifndef PHONE_LINE_CALL_CONTROLLER_ASSERT_SVH
`define PHONE_LINE_CALL_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PLCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plcc assertion failed");
// antecedent implies consequent in the next cycle
`define PLCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plcc assertion failed");
`else
`define PLCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/plcc_pkg.sv
`timescale 1ns / 1ps

package plcc_pkg;

	localparam int unsigned CFG_W = 16;

	// configuration register indexes
	localparam logic [2:0] CFG_DEBOUNCE       = 3'd0;
	localparam logic [2:0] CFG_DIAL_DELAY     = 3'd1;
	localparam logic [2:0] CFG_DIAL_TONE      = 3'd2;
	localparam logic [2:0] CFG_BUSY_PERIOD    = 3'd3;
	localparam logic [2:0] CFG_BUSY_BURST     = 3'd4;
	localparam logic [2:0] CFG_RINGBACK_PER   = 3'd5;
	localparam logic [2:0] CFG_RINGBACK_BURST = 3'd6;
	localparam logic [2:0] CFG_RINGER_TOGGLE  = 3'd7;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] RST_DEBOUNCE       = 16'd300;
	localparam logic [CFG_W-1:0] RST_DIAL_DELAY     = 16'd2000;
	localparam logic [CFG_W-1:0] RST_DIAL_TONE      = 16'd5000;
	localparam logic [CFG_W-1:0] RST_BUSY_PERIOD    = 16'd500;
	localparam logic [CFG_W-1:0] RST_BUSY_BURST     = 16'd250;
	localparam logic [CFG_W-1:0] RST_RINGBACK_PER   = 16'd4000;
	localparam logic [CFG_W-1:0] RST_RINGBACK_BURST = 16'd1500;
	localparam logic [CFG_W-1:0] RST_RINGER_TOGGLE  = 16'd2000;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] dial_delay_ms;
		logic [CFG_W-1:0] dial_tone_ms;
		logic [CFG_W-1:0] busy_period_ms;
		logic [CFG_W-1:0] busy_burst_ms;
		logic [CFG_W-1:0] ringback_period_ms;
		logic [CFG_W-1:0] ringback_burst_ms;
		logic [CFG_W-1:0] ringer_toggle_ms;
	} cfg_t;

	typedef struct packed {
		logic caller_off_hook_raw;
		logic dest_off_hook_raw;
	} in_t;

	typedef struct packed {
		logic [2:0] line_state;
		logic       tone_on;
		logic       ringer_drive;
		logic       connect_drive;
		logic       send_caller_id;
	} out_t;

endpackage

FILE: design/plcc_cfg_regs.sv
`timescale 1ns / 1ps

module plcc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [plcc_pkg::CFG_W-1:0] cfg_data,
	output plcc_pkg::cfg_t             cfg
);
	import plcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms        <= RST_DEBOUNCE;
			cfg_q.dial_delay_ms      <= RST_DIAL_DELAY;
			cfg_q.dial_tone_ms       <= RST_DIAL_TONE;
			cfg_q.busy_period_ms     <= RST_BUSY_PERIOD;
			cfg_q.busy_burst_ms      <= RST_BUSY_BURST;
			cfg_q.ringback_period_ms <= RST_RINGBACK_PER;
			cfg_q.ringback_burst_ms  <= RST_RINGBACK_BURST;
			cfg_q.ringer_toggle_ms   <= RST_RINGER_TOGGLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:       cfg_q.debounce_ms        <= cfg_data;
				CFG_DIAL_DELAY:     cfg_q.dial_delay_ms      <= cfg_data;
				CFG_DIAL_TONE:      cfg_q.dial_tone_ms       <= cfg_data;
				CFG_BUSY_PERIOD:    cfg_q.busy_period_ms     <= cfg_data;
				CFG_BUSY_BURST:     cfg_q.busy_burst_ms      <= cfg_data;
				CFG_RINGBACK_PER:   cfg_q.ringback_period_ms <= cfg_data;
				CFG_RINGBACK_BURST: cfg_q.ringback_burst_ms  <= cfg_data;
				CFG_RINGER_TOGGLE:  cfg_q.ringer_toggle_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/plcc_debounce.sv
`timescale 1ns / 1ps

module plcc_debounce #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       raw,
	input  logic [plcc_pkg::CFG_W-1:0] debounce_ms,
	output logic                       level_next
);
	import plcc_pkg::*;

	localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic                  held_q;
	logic                  deb_q;
	logic [TIMER_BITS-1:0] age_q;
	logic                  held_d;
	logic [TIMER_BITS-1:0] age_d;

	always_comb begin
		held_d = held_q;
		age_d  = (age_q == '1) ? age_q : age_q + 1'b1;
		if (raw != held_q) begin
			held_d = raw;
			age_d  = '0;
		end
		level_next = (CW'(age_d) > CW'(debounce_ms)) ? held_d : deb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			deb_q  <= 1'b0;
			age_q  <= '0;
		end else if (adv) begin
			held_q <= held_d;
			deb_q  <= level_next;
			age_q  <= age_d;
		end
	end

endmodule

FILE: design/plcc_call_fsm.sv
`timescale 1ns / 1ps
`include "phone_line_call_controller_assert.svh"

module plcc_call_fsm #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           caller,
	input  logic           dest,
	input  plcc_pkg::cfg_t cfg,
	output plcc_pkg::out_t result
);
	import plcc_pkg::*;

	localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	typedef enum logic [2:0] {
		ST_UNINIT    = 3'd0,
		ST_IDLE      = 3'd1,
		ST_BUSY      = 3'd2,
		ST_WAIT      = 3'd3,
		ST_CALLING   = 3'd4,
		ST_CONNECTED = 3'd5
	} line_state_t;

	line_state_t           state_q, st;
	logic [TIMER_BITS-1:0] state_age_q, tone_age_q, ringer_age_q;
	logic [TIMER_BITS-1:0] sa, ta, ra;
	logic [CFG_W-1:0]      tone_left_q, tl;
	logic                  ringer_q, rl, cid;
	logic [1:0]            ring_count_q, rc;
	out_t                  res_q;

	function automatic logic [TIMER_BITS-1:0] sat_up(input logic [TIMER_BITS-1:0] a);
		return (a == '1) ? a : a + 1'b1;
	endfunction

	function automatic logic gt(input logic [TIMER_BITS-1:0] a, input logic [CFG_W-1:0] b);
		return CW'(a) > CW'(b);
	endfunction

	always_comb begin
		sa  = sat_up(state_age_q);
		ta  = sat_up(tone_age_q);
		ra  = sat_up(ringer_age_q);
		tl  = (tone_left_q != '0) ? tone_left_q - 1'b1 : tone_left_q;
		rc  = ring_count_q;
		rl  = ringer_q;
		cid = 1'b0;
		st  = state_q;

		unique case (state_q)
			ST_BUSY: begin
				if (!caller && !dest) st = ST_IDLE;
			end
			ST_WAIT: begin
				rc = 2'd0;
				if (!caller) st = ST_IDLE;
				// autodial wins over hang-up in the same tick
				if (gt(sa, cfg.dial_delay_ms)) st = ST_CALLING;
			end
			ST_CALLING: begin
				if (!caller) st = ST_IDLE;
				if (caller && dest) st = ST_CONNECTED;
			end
			ST_CONNECTED: begin
				if (!caller) st = ST_BUSY;
			end
			default: begin
				// uninitialized falls through to the idle decision
				if (caller && dest) st = ST_BUSY;
				else if (caller) st = ST_WAIT;
				else st = ST_IDLE;
			end
		endcase

		if ((state_q == ST_BUSY || state_q == ST_CALLING || state_q == ST_WAIT)
				&& st != state_q) begin
			tl = '0;
			rl = 1'b0;
			ta = '1;
		end
		if (st == ST_WAIT && state_q != ST_WAIT) tl = cfg.dial_tone_ms;
		if (st == ST_BUSY && gt(ta, cfg.busy_period_ms)) begin
			tl = cfg.busy_burst_ms;
			ta = '0;
		end
		if (st == ST_CALLING) begin
			if (gt(ta, cfg.ringback_period_ms)) begin
				tl = cfg.ringback_burst_ms;
				ta = '0;
			end
			if (gt(ra, cfg.ringer_toggle_ms)) begin
				// second toggle of the call asks for caller id
				if (rc == 2'd1) cid = 1'b1;
				rl = ~rl;
				ra = '0;
				if (rc != 2'd2) rc = rc + 2'd1;
			end
		end
		if (st == ST_CONNECTED) rl = 1'b0;
		if (st != state_q) sa = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_UNINIT;
			state_age_q  <= '0;
			tone_age_q   <= '1;
			ringer_age_q <= '1;
			tone_left_q  <= '0;
			ringer_q     <= 1'b0;
			ring_count_q <= 2'd0;
			res_q        <= '0;
		end else if (adv) begin
			state_q              <= st;
			state_age_q          <= sa;
			tone_age_q           <= ta;
			ringer_age_q         <= ra;
			tone_left_q          <= tl;
			ringer_q             <= rl;
			ring_count_q         <= rc;
			res_q.line_state     <= st;
			res_q.tone_on        <= (tl != '0);
			res_q.ringer_drive   <= rl;
			res_q.connect_drive  <= (st == ST_CONNECTED);
			res_q.send_caller_id <= cid;
		end
	end

	assign result = res_q;

	`PLCC_ASSERT_IMPL(a_ring_sat, clk, arst_n, 1'b1, ring_count_q != 2'd3)
	`PLCC_ASSERT_IMPL(a_cid_calling, clk, arst_n, res_q.send_caller_id,
		res_q.line_state == ST_CALLING && ring_count_q == 2'd2)
	`PLCC_ASSERT_IMPL(a_connect_quiet, clk, arst_n, res_q.connect_drive, !res_q.ringer_drive)
	`PLCC_ASSERT_NEXT(a_hold, clk, arst_n, !adv, $stable(state_q) && $stable(res_q))
	`PLCC_ASSERT_NEXT(a_autodial, clk, arst_n, adv && state_q == ST_WAIT && st == ST_CALLING,
		ring_count_q != 2'd2)

endmodule

FILE: design/phone_line_call_controller.sv
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// input     in         in_valid / in_stall          in_data   (plcc_pkg::in_t)
// output    out        out_valid / out_stall        out_data  (plcc_pkg::out_t)
// config    in         cfg_we, write only           cfg_index, cfg_data
//
// one tick per clock cycle sustained while out_stall is low; a tick is taken into the input
// register at the accepting edge and its result is written into the result register on adv
// reset puts the configuration at its default timings and the line uninitialized
// out_stall holds the result register; the input register still takes one more
// tick, and in_stall rises only when both registers are full and out_stall is high

module phone_line_call_controller #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  plcc_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output plcc_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [plcc_pkg::CFG_W-1:0] cfg_data
);
	import plcc_pkg::*;

	cfg_t cfg;
	in_t  in_s1;
	logic in_valid_s1;
	logic out_valid_q;
	logic adv;
	logic caller_lvl, dest_lvl;

	// s1 moves into the result register when that register is free or draining
	assign adv      = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) in_valid_s1 <= 1'b1;
			else if (adv) in_valid_s1 <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_s1 <= in_data;
	end

	plcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plcc_debounce #(.TIMER_BITS(TIMER_BITS)) u_deb_caller (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.raw         (in_s1.caller_off_hook_raw),
		.debounce_ms (cfg.debounce_ms),
		.level_next  (caller_lvl)
	);

	plcc_debounce #(.TIMER_BITS(TIMER_BITS)) u_deb_dest (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.raw         (in_s1.dest_off_hook_raw),
		.debounce_ms (cfg.debounce_ms),
		.level_next  (dest_lvl)
	);

	plcc_call_fsm #(.TIMER_BITS(TIMER_BITS)) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.caller (caller_lvl),
		.dest   (dest_lvl),
		.cfg    (cfg),
		.result (out_data)
	);

	assign out_valid = out_valid_q;

endmodule
